FILE: rtl/kbsl_pkg.sv
// ----------------------------------------------------------------------------
// kbsl_pkg - shared types and constants of the k-best sorted insertion list
// Field widths, configuration register indexes and the control/status
// structs that join the controller and the datapath.
// ----------------------------------------------------------------------------
package kbsl_pkg;

    localparam int DIST_W      = 32;
    localparam int INDEX_W     = 16;
    localparam int RANK_W      = 5;
    localparam int KREG_W      = 6;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 8;
    localparam int IN_TDATA_W  = 48;  // distance + index
    localparam int OUT_TDATA_W = 56;  // distance + index + rank, padded to bytes

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_K_IN_USE     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_EXCLUDE_ZERO = 2'd1;

    localparam logic [KREG_W-1:0] K_IN_USE_RESET     = 6'd8;
    localparam logic              EXCLUDE_ZERO_RESET = 1'b1;

    typedef struct packed {
        logic              in_ready;     // collecting candidates
        logic              take;         // candidate transfer this cycle
        logic              load_entry;   // load list entry rd_idx into output reg
        logic              load_empty;   // load the empty-list marker result
        logic              clear_count;  // query drained, empty the list
        logic [RANK_W-1:0] rd_idx;       // drain pointer
    } kbsl_cmd_t;

    typedef struct packed {
        logic out_free;    // output register can take a result this cycle
        logic list_empty;  // no entries held
        logic at_last;     // rd_idx points at the last held entry
    } kbsl_sts_t;

endpackage

FILE: rtl/kbsl_ctrl.sv
// ----------------------------------------------------------------------------
// kbsl_ctrl - controller of the k-best sorted insertion list
// Collects candidates, then walks the list once per query end to emit it.
// ----------------------------------------------------------------------------
module kbsl_ctrl
    import kbsl_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    input  logic      in_last,
    input  kbsl_sts_t sts,
    output kbsl_cmd_t cmd
);

    localparam logic ST_RUN   = 1'b0;
    localparam logic ST_DRAIN = 1'b1;

    logic              state_reg;
    logic              state_next;
    logic [RANK_W-1:0] rd_idx_reg;
    logic [RANK_W-1:0] rd_idx_next;

    always_comb
    begin
        cmd         = '0;
        cmd.rd_idx  = rd_idx_reg;
        state_next  = state_reg;
        rd_idx_next = rd_idx_reg;
        case (state_reg)
            ST_RUN:
            begin
                cmd.in_ready = 1'b1;
                cmd.take     = in_valid;
                if (in_valid && in_last)
                begin
                    state_next  = ST_DRAIN;
                    rd_idx_next = '0;
                end
            end
            ST_DRAIN:
            begin
                if (sts.out_free)
                begin
                    if (sts.list_empty)
                    begin
                        cmd.load_empty = 1'b1;
                        state_next     = ST_RUN;
                    end
                    else
                    begin
                        cmd.load_entry = 1'b1;
                        if (sts.at_last)
                        begin
                            cmd.clear_count = 1'b1;
                            state_next      = ST_RUN;
                        end
                        else
                        begin
                            rd_idx_next = rd_idx_reg + RANK_W'(1);
                        end
                    end
                end
            end
            default:
            begin
                state_next = ST_RUN;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_RUN;
            rd_idx_reg <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            rd_idx_reg <= rd_idx_next;
        end
    end

endmodule

FILE: rtl/kbsl_dp.sv
// ----------------------------------------------------------------------------
// kbsl_dp - datapath of the k-best sorted insertion list
// K entry registers with parallel compare-and-shift insertion, the fill
// count, and the output register for ranked results.
// ----------------------------------------------------------------------------
module kbsl_dp
    import kbsl_pkg::*;
#(
    parameter int K = 8
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  kbsl_cmd_t          cmd,
    output kbsl_sts_t          sts,
    input  logic [DIST_W-1:0]  cand_distance,
    input  logic [INDEX_W-1:0] ref_index,
    input  logic [KREG_W-1:0]  k_in_use,
    input  logic               exclude_zero,
    input  logic               m_ready,
    output logic               out_valid,
    output logic [DIST_W-1:0]  out_distance,
    output logic [INDEX_W-1:0] out_index,
    output logic [RANK_W-1:0]  out_rank,
    output logic               out_entry_valid,
    output logic               out_last
);

    localparam int CW = $clog2(K + 1);          // fill count width
    localparam int IW = (K > 1) ? $clog2(K) : 1;

    logic [DIST_W-1:0]  dist_reg  [K];
    logic [INDEX_W-1:0] index_reg [K];
    logic [DIST_W-1:0]  dist_next [K];
    logic [INDEX_W-1:0] index_next[K];
    logic [K-1:0]       wr_en;

    logic [CW-1:0]      count_reg;
    logic [CW-1:0]      count_next;

    logic [KREG_W:0]    k_wide;
    logic [CW-1:0]      k_eff;
    logic [CW-1:0]      n_eff;
    logic [K-1:0]       lt;        // entry held and strictly below the candidate
    logic [K-1:0]       at_end;    // entry is the last slot of the effective k
    logic               drop;
    logic               excluded;
    logic               ins;

    logic               out_valid_reg;
    logic [DIST_W-1:0]  out_dist_reg;
    logic [INDEX_W-1:0] out_index_reg;
    logic [RANK_W-1:0]  out_rank_reg;
    logic               out_ev_reg;
    logic               out_last_reg;

    // clamp k to 1..K
    always_comb
    begin
        k_wide = {1'b0, k_in_use};
        if (k_wide == '0)
            k_eff = CW'(1);
        else if (k_wide > (KREG_W + 1)'(K))
            k_eff = CW'(K);
        else
            k_eff = k_wide[CW-1:0];
    end

    assign n_eff = (count_reg > k_eff) ? k_eff : count_reg;

    always_comb
    begin
        for (int i = 0; i < K; i++)
        begin
            lt[i]     = (CW'(i) < n_eff) && (dist_reg[i] < cand_distance);
            at_end[i] = ((CW'(i) + CW'(1)) == k_eff);
        end
    end

    // sorted list: lt is a prefix, so a hit at the last slot means no room
    assign drop     = |(lt & at_end);
    assign excluded = exclude_zero && (cand_distance == '0);
    assign ins      = cmd.take && !excluded && !drop;

    for (genvar gi = 0; gi < K; gi++)
    begin : g_entry
        always_comb
        begin
            wr_en[gi] = ins && !lt[gi];
            if (gi == 0)
            begin
                dist_next[gi]  = cand_distance;
                index_next[gi] = ref_index;
            end
            else if (lt[(gi > 0) ? gi - 1 : 0])
            begin
                dist_next[gi]  = cand_distance;
                index_next[gi] = ref_index;
            end
            else
            begin
                dist_next[gi]  = dist_reg[(gi > 0) ? gi - 1 : 0];
                index_next[gi] = index_reg[(gi > 0) ? gi - 1 : 0];
            end
        end

        always_ff @(posedge clk)
        begin
            if (wr_en[gi])
            begin
                dist_reg[gi]  <= dist_next[gi];
                index_reg[gi] <= index_next[gi];
            end
        end
    end

    always_comb
    begin
        count_next = count_reg;
        if (cmd.clear_count)
            count_next = '0;
        else if (cmd.take)
        begin
            if (ins && (n_eff < k_eff))
                count_next = n_eff + CW'(1);
            else
                count_next = n_eff;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= '0;
        else
            count_reg <= count_next;
    end

    assign sts.out_free   = !out_valid_reg || m_ready;
    assign sts.list_empty = (count_reg == '0);
    assign sts.at_last    = (({1'b0, cmd.rd_idx} + (RANK_W + 1)'(1)) ==
                             (RANK_W + 1)'(count_reg));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.load_entry || cmd.load_empty)
            out_valid_reg <= 1'b1;
        else if (m_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_entry)
        begin
            out_dist_reg  <= dist_reg[cmd.rd_idx[IW-1:0]];
            out_index_reg <= index_reg[cmd.rd_idx[IW-1:0]];
            out_rank_reg  <= cmd.rd_idx;
            out_ev_reg    <= 1'b1;
            out_last_reg  <= sts.at_last;
        end
        else if (cmd.load_empty)
        begin
            out_dist_reg  <= '0;
            out_index_reg <= '0;
            out_rank_reg  <= '0;
            out_ev_reg    <= 1'b0;
            out_last_reg  <= 1'b1;
        end
    end

    assign out_valid       = out_valid_reg;
    assign out_distance    = out_dist_reg;
    assign out_index       = out_index_reg;
    assign out_rank        = out_rank_reg;
    assign out_entry_valid = out_ev_reg;
    assign out_last        = out_last_reg;

endmodule

FILE: rtl/k_best_sorted_insert_list.sv
// Latency: a candidate is inserted in the cycle it transfers; one candidate per cycle.
// After a transfer with tlast the list of n entries drains at one result per cycle
// while m_tready allows (one result for an empty list); s_tready stays low until the walk ends.
// Drain rate is set by the single output register, read at one list entry per cycle.
// Reset: fill count, controller and output valid cleared, k_in_use = 8,
// exclude_zero = 1; list entries are not cleared (only held entries are read).
// ----------------------------------------------------------------------------
// k_best_sorted_insert_list - top-k nearest neighbour sorted list
// Keeps the k smallest distances of one query with their reference index,
// emits them in rank order at end of query and starts over.
// ----------------------------------------------------------------------------
module k_best_sorted_insert_list
    import kbsl_pkg::*;
#(
    parameter int K = 8    // list depth, 1..32
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    // candidate stream
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [IN_TDATA_W-1:0]  s_tdata,   // [31:0] cand_distance, [47:32] ref_index
    input  logic                   s_tlast,   // end_of_query
    // ranked result stream
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_TDATA_W-1:0] m_tdata,   // [31:0] out_distance, [47:32] out_index,
                                              // [52:48] rank, [55:53] zero
    output logic                   m_tuser,   // entry_valid
    output logic                   m_tlast,   // last_result
    // configuration writes
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    kbsl_cmd_t          cmd;
    kbsl_sts_t          sts;

    logic [KREG_W-1:0]  k_in_use_reg;
    logic               exclude_zero_reg;

    logic [DIST_W-1:0]  out_distance;
    logic [INDEX_W-1:0] out_index;
    logic [RANK_W-1:0]  out_rank;

    // config registers: always ready, writes to unknown indexes are dropped
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            k_in_use_reg     <= K_IN_USE_RESET;
            exclude_zero_reg <= EXCLUDE_ZERO_RESET;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_K_IN_USE:     k_in_use_reg     <= cfg_data[KREG_W-1:0];
                REG_EXCLUDE_ZERO: exclude_zero_reg <= cfg_data[0];
                default:          ;
            endcase
        end
    end

    kbsl_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_last  (s_tlast),
        .sts      (sts),
        .cmd      (cmd)
    );

    kbsl_dp #(.K(K)) u_dp
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .sts             (sts),
        .cand_distance   (s_tdata[DIST_W-1:0]),
        .ref_index       (s_tdata[DIST_W +: INDEX_W]),
        .k_in_use        (k_in_use_reg),
        .exclude_zero    (exclude_zero_reg),
        .m_ready         (m_tready),
        .out_valid       (m_tvalid),
        .out_distance    (out_distance),
        .out_index       (out_index),
        .out_rank        (out_rank),
        .out_entry_valid (m_tuser),
        .out_last        (m_tlast)
    );

    assign s_tready = cmd.in_ready;
    assign m_tdata  = {(OUT_TDATA_W - DIST_W - INDEX_W - RANK_W)'(0),
                       out_rank, out_index, out_distance};

    // ------------------------------------------------------------------------
    // checks
    // ------------------------------------------------------------------------

    // a query end always starts a drain, so no candidate is taken right after it
    a_drain_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready && s_tlast) |=> !s_tready)
        else $error("candidate taken right after end of query");

    // the empty-list marker is a single final result of rank zero
    a_empty_marker: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tuser) |-> (m_tlast && (m_tdata[52:48] == '0)))
        else $error("empty-list result malformed");

    // ranks stay inside the list depth
    a_rank_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> ({1'b0, m_tdata[52:48]} < (RANK_W + 1)'(K)))
        else $error("rank beyond list depth");

    // an output transfer that is not the last of a walk is followed by the next rank
    a_rank_step: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tready && !m_tlast) |=>
            (m_tvalid && (m_tdata[52:48] == ($past(m_tdata[52:48]) + RANK_W'(1)))))
        else $error("drain skipped a rank");

endmodule

FILE: tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top - testbench of the k-best sorted insertion list
// Streams queries of candidate distances into the list and checks every
// ranked neighbour it sends back against a behavioral copy of the list
// kept here. Register writes are placed between queries, and also in the
// middle of a query, to move k and the zero-distance exclusion about.
// ----------------------------------------------------------------------------
module tb_top
    import kbsl_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int K_DEPTH       = 8;
    localparam int RANDOM_ITEMS  = 290;
    localparam int SETTLE_CYCLES = 4;     // after the last result, before a register write
    localparam int END_CYCLES    = 20;    // quiet time at the end, catches stray results
    localparam int IDLE_LIMIT    = 3000;  // well above the longest gap or stall that pick_gap draws

    // register indexes with nothing behind them; writes there must change nothing
    localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED_LO = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED_HI = 2'd3;

    typedef struct packed {
        logic [DIST_W-1:0]  distance;
        logic [INDEX_W-1:0] index;
        logic               eoq;      // last candidate of the query
    } candidate_t;

    typedef struct packed {
        logic [DIST_W-1:0]  distance;
        logic [INDEX_W-1:0] index;
        logic [RANK_W-1:0]  rank;
        logic               valid;    // entry_valid
        logic               last;     // last_result
    } neighbour_t;

    // ------------------------------------------------------------------------
    // clock, reset and DUT
    // ------------------------------------------------------------------------
    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    always #5 clk = ~clk;

    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata   = '0;   // [31:0] cand_distance, [47:32] ref_index
    logic                   s_tlast   = 1'b0; // end_of_query
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;          // [31:0] distance, [47:32] index, [52:48] rank
    logic                   m_tuser;          // entry_valid
    logic                   m_tlast;          // last_result
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_IDX_W-1:0]   cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data  = '0;

    k_best_sorted_insert_list #(.K(K_DEPTH)) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // ------------------------------------------------------------------------
    // behavioral copy of the list
    // ------------------------------------------------------------------------
    logic [DIST_W-1:0]  near_dist [K_DEPTH];
    logic [INDEX_W-1:0] near_idx  [K_DEPTH];
    int                 held_count = 0;
    logic [KREG_W-1:0]  k_setting  = K_IN_USE_RESET;
    logic               drop_zero  = EXCLUDE_ZERO_RESET;

    neighbour_t ranked_q[$];     // neighbours still owed by the DUT, oldest first
    candidate_t pending_q[$];    // candidates not yet handed to the driver

    int n_queued      = 0;
    int n_accepted    = 0;
    int queries_done  = 0;
    int empty_lists   = 0;
    int zeros_dropped = 0;
    int results_seen  = 0;
    int reg_writes    = 0;
    int mismatches    = 0;

    // Insert one accepted candidate; on end of query queue the ranked list.
    task automatic insert_candidate(input candidate_t c);
        int k_eff;
        int pos;
        int tail;
        int t;
        neighbour_t nb;
        k_eff = (k_setting < 1) ? 1 : ((k_setting > K_DEPTH) ? K_DEPTH : int'(k_setting));
        // k may have been lowered since the last candidate: cut the list
        if (held_count > k_eff)
            held_count = k_eff;
        if (drop_zero && c.distance == '0) begin
            zeros_dropped++;
        end
        else begin
            // first slot whose distance is not below ours, so ties go in front
            pos = 0;
            while (pos < held_count && near_dist[pos] < c.distance)
                pos++;
            if (pos < k_eff) begin
                tail = (held_count < k_eff) ? held_count : k_eff - 1;
                for (t = tail; t > pos; t--) begin
                    near_dist[t] = near_dist[t-1];
                    near_idx[t]  = near_idx[t-1];
                end
                near_dist[pos] = c.distance;
                near_idx[pos]  = c.index;
                if (held_count < k_eff)
                    held_count++;
            end
        end
        if (c.eoq) begin
            queries_done++;
            if (held_count == 0) begin
                // empty list still answers with one marker result
                nb = '{distance: '0, index: '0, rank: '0, valid: 1'b0, last: 1'b1};
                ranked_q.push_back(nb);
                empty_lists++;
            end
            else begin
                for (t = 0; t < held_count; t++) begin
                    nb.distance = near_dist[t];
                    nb.index    = near_idx[t];
                    nb.rank     = RANK_W'(t);
                    nb.valid    = 1'b1;
                    nb.last     = (t + 1 == held_count);
                    ranked_q.push_back(nb);
                end
            end
            held_count = 0;
        end
    endtask

    // ------------------------------------------------------------------------
    // idle patterns: mostly short gaps, a few long ones, and gap-free bursts
    // ------------------------------------------------------------------------
    function automatic int pick_gap(input bit burst);
        int r;
        if (burst)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 10);
        return $urandom_range(11, 40);
    endfunction

    // ------------------------------------------------------------------------
    // candidate driver: one transfer per handshake, gaps between items
    // ------------------------------------------------------------------------
    candidate_t on_bus;
    int         src_gap   = 0;
    bit         src_burst = 1'b0;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            src_gap  = 0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                // predict first, then count: the stimulus side keys off the count
                insert_candidate(on_bus);
                n_accepted++;
            end
            if ($urandom_range(0, 63) == 0)
                src_burst = ~src_burst;
            if (!s_tvalid || s_tready)
            begin
                if (src_gap > 0 || pending_q.size() == 0)
                begin
                    if (src_gap > 0)
                        src_gap--;
                    s_tvalid <= 1'b0;
                end
                else
                begin
                    on_bus   = pending_q.pop_front();
                    s_tdata  <= {on_bus.index, on_bus.distance};
                    s_tlast  <= on_bus.eoq;
                    s_tvalid <= 1'b1;
                    src_gap  = pick_gap(src_burst);
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // result monitor: random back-pressure, field-by-field compare
    // ------------------------------------------------------------------------
    int sink_stall = 0;
    bit sink_burst = 1'b0;

    task automatic check_field(input string name, input longint unsigned want,
                               input longint unsigned got);
        if (want != got)
        begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        neighbour_t want;
        if (!rst_n)
        begin
            m_tready   <= 1'b0;
            sink_stall = 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                results_seen++;
                if (ranked_q.size() == 0)
                begin
                    $error("result transfer with nothing expected: distance 0x%0h index 0x%0h",
                           m_tdata[DIST_W-1:0], m_tdata[DIST_W +: INDEX_W]);
                    mismatches++;
                end
                else
                begin
                    want = ranked_q.pop_front();
                    check_field("out_distance", want.distance, m_tdata[DIST_W-1:0]);
                    check_field("out_index", want.index, m_tdata[DIST_W +: INDEX_W]);
                    check_field("rank", want.rank, m_tdata[DIST_W+INDEX_W +: RANK_W]);
                    check_field("entry_valid", want.valid, m_tuser);
                    check_field("last_result", want.last, m_tlast);
                end
            end
            if ($urandom_range(0, 63) == 0)
                sink_burst = ~sink_burst;
            if (sink_stall > 0)
            begin
                sink_stall--;
                m_tready <= 1'b0;
            end
            else
            begin
                m_tready <= 1'b1;
                sink_stall = pick_gap(sink_burst);
            end
        end
    end

    // ------------------------------------------------------------------------
    // watchdog: too long without any transfer means the DUT hung
    // ------------------------------------------------------------------------
    int quiet_cycles = 0;

    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)
                   || (cfg_valid && cfg_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= IDLE_LIMIT)
        begin
            $display("watchdog: no transfer for %0d cycles, %0d results outstanding",
                     IDLE_LIMIT, ranked_q.size());
            $display("FAILED: results differ");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------------
    function automatic void queue_candidate(input logic [DIST_W-1:0] d,
                                            input logic [INDEX_W-1:0] i, input logic e);
        pending_q.push_back('{distance: d, index: i, eoq: e});
        n_queued++;
    endfunction

    // Every candidate taken and every result back, then a settle wait since
    // a candidate without end mark leaves no result to wait for. Ends on a
    // rising edge.
    task automatic wait_idle();
        do
            @(posedge clk);
        while (n_accepted != n_queued || ranked_q.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Called on a rising edge; returns on one with cfg_valid already lowered
    // and one bubble cycle behind it.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == REG_K_IN_USE)
            k_setting = data[KREG_W-1:0];
        else if (idx == REG_EXCLUDE_ZERO)
            drop_zero = data[0];
        reg_writes++;
        @(posedge clk);
    endtask

    // Mix of full-range distances, small values that tie often, zero and max.
    function automatic logic [DIST_W-1:0] random_distance();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0)
            return '0;
        if (r == 1)
            return '1;
        if (r < 5)
            return DIST_W'($urandom_range(0, 7));
        return DIST_W'($urandom);
    endfunction

    // ------------------------------------------------------------------------
    // test sequence
    // ------------------------------------------------------------------------
    initial
    begin
        int  fed;
        int  n_queries;
        int  len;
        int  q;
        int  j;
        int  pick;
        logic [KREG_W-1:0] k_pick;
        bit  close_phase;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // --- directed, reset settings: k = 8, zero distances excluded ---
        @(negedge clk);
        // only a zero-distance candidate: empty list marker
        queue_candidate('0, 16'h1234, 1'b1);
        // overfill the list: ties, an excluded zero, drops at the end
        queue_candidate('1, '1, 1'b0);
        queue_candidate(32'd1, 16'd0, 1'b0);
        queue_candidate(32'd5, 16'd1, 1'b0);
        queue_candidate(32'd5, 16'd2, 1'b0);       // tie goes in front of the older 5
        queue_candidate('0, 16'd3, 1'b0);          // excluded
        queue_candidate(32'd3, 16'd4, 1'b0);
        queue_candidate(32'd2, 16'd5, 1'b0);
        queue_candidate(32'd8, 16'd6, 1'b0);
        queue_candidate(32'd7, 16'd7, 1'b0);
        queue_candidate(32'd6, 16'd8, 1'b0);       // list full, max distance falls out
        queue_candidate(32'd9, 16'd9, 1'b0);       // lands past the end, dropped
        queue_candidate(32'd8, 16'd10, 1'b1);      // ties the last entry and replaces it
        wait_idle();

        // zero distances kept, k = 1
        write_reg(REG_EXCLUDE_ZERO, 8'h00);
        write_reg(REG_K_IN_USE, 8'd1);
        @(negedge clk);
        queue_candidate('0, 16'd11, 1'b0);
        queue_candidate('0, 16'd12, 1'b1);         // zero tie, newest wins
        queue_candidate(32'd4, 16'd13, 1'b1);
        wait_idle();

        // k = 0 behaves as 1
        write_reg(REG_K_IN_USE, 8'd0);
        @(negedge clk);
        queue_candidate(32'd7, 16'd14, 1'b0);
        queue_candidate(32'd3, 16'd15, 1'b1);
        wait_idle();

        // k lowered in the middle of a query cuts the held list
        write_reg(REG_K_IN_USE, 8'd8);
        @(negedge clk);
        queue_candidate(32'd10, 16'd20, 1'b0);
        queue_candidate(32'd20, 16'd21, 1'b0);
        queue_candidate(32'd30, 16'd22, 1'b0);
        queue_candidate(32'd40, 16'd23, 1'b0);
        wait_idle();
        write_reg(REG_K_IN_USE, 8'd2);
        @(negedge clk);
        queue_candidate(32'd25, 16'd24, 1'b1);     // past the cut list, dropped
        wait_idle();

        // --- random phases: new settings, then a few queries ---
        fed = 0;
        while (fed < RANDOM_ITEMS)
        begin
            pick = $urandom_range(0, 7);
            case (pick)
                0:       k_pick = 6'd1;
                1:       k_pick = 6'd8;
                2:       k_pick = 6'd0;
                3:       k_pick = 6'd32;
                4:       k_pick = 6'd63;
                default: k_pick = KREG_W'($urandom_range(1, K_DEPTH));
            endcase
            // upper data bits carry noise that the register must ignore
            if ($urandom_range(0, 4) != 0)
                write_reg(REG_K_IN_USE, {CFG_DATA_W'($urandom) & 8'hC0} | 8'(k_pick));
            if ($urandom_range(0, 2) != 0)
                write_reg(REG_EXCLUDE_ZERO, CFG_DATA_W'($urandom));
            if ($urandom_range(0, 9) == 0)
                write_reg(($urandom_range(0, 1) != 0) ? REG_UNMAPPED_HI : REG_UNMAPPED_LO,
                          CFG_DATA_W'($urandom));
            // most phases end on a query boundary; the rest leave a query open
            close_phase = ($urandom_range(0, 4) != 0);
            n_queries   = $urandom_range(1, 4);
            @(negedge clk);
            for (q = 0; q < n_queries; q++)
            begin
                len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 30)
                                                  : $urandom_range(1, 12);
                for (j = 0; j < len; j++)
                    queue_candidate(random_distance(), INDEX_W'($urandom_range(0, 65535)),
                                    (j == len - 1) && (close_phase || q != n_queries - 1));
                fed += len;
            end
            wait_idle();
        end

        // close a query that may still be open, then drain
        @(negedge clk);
        queue_candidate(DIST_W'($urandom), INDEX_W'($urandom_range(0, 65535)), 1'b1);
        wait_idle();
        repeat (END_CYCLES) @(posedge clk);

        $display("Ran %0d queries (%0d ended empty), checked %0d ranked results, %0d zero",
                 queries_done, empty_lists, results_seen, zeros_dropped);
        $display("distances excluded; %0d register writes, k from 0 to 63, both exclusion modes",
                 reg_writes);
        if (mismatches == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
